[src/pwhc_pkg.sv]
package pwhc_pkg;

  localparam int unsigned CHANNELS  = 8;
  localparam int unsigned CH_W      = 3;
  localparam int unsigned VALUE_W   = 16;
  localparam int unsigned WORD_W    = 16;
  localparam int unsigned CNT_W     = 20;
  localparam int unsigned LVL_W     = 7;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned PROD_W    = 23;

  // action codes
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_DIM   = 2'd1;
  localparam logic [1:0] ACT_LIGHT = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_M4_COMFORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_M4_ECO     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M5_COMFORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M5_ECO     = 2'd3;

  localparam logic [CNT_W-1:0] RST_M4_COMFORT = 20'd293000;
  localparam logic [CNT_W-1:0] RST_M4_ECO     = 20'd7000;
  localparam logic [CNT_W-1:0] RST_M5_COMFORT = 20'd297000;
  localparam logic [CNT_W-1:0] RST_M5_ECO     = 20'd3000;

  // channel modes
  localparam logic [MODE_W-1:0] MODE_NONE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_1    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_2    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_3    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_4    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_5    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_6    = 3'd6;

  // pilot-wire codes
  localparam logic [1:0] CODE_COMFORT = 2'b00;
  localparam logic [1:0] CODE_MODE1   = 2'b10;
  localparam logic [1:0] CODE_MODE2   = 2'b01;
  localparam logic [1:0] CODE_FORCED  = 2'b11;

  localparam logic [LVL_W-1:0] LVL_MAX    = 7'd100;
  localparam logic [LVL_W-1:0] LVL_BAND_1 = 7'd10;
  localparam logic [LVL_W-1:0] LVL_BAND_2 = 7'd20;
  localparam logic [LVL_W-1:0] LVL_BAND_3 = 7'd30;
  localparam logic [LVL_W-1:0] LVL_BAND_4 = 7'd40;
  localparam logic [LVL_W-1:0] LVL_BAND_5 = 7'd50;

  typedef struct packed {
    logic [LVL_W-1:0]  level;
    logic [MODE_W-1:0] mode;
    logic              comfort;
    logic [CNT_W-1:0]  countdown;
  } entry_t;

  typedef struct packed {
    logic [CNT_W-1:0] m4_comfort;
    logic [CNT_W-1:0] m4_eco;
    logic [CNT_W-1:0] m5_comfort;
    logic [CNT_W-1:0] m5_eco;
  } phase_cfg_t;

  typedef struct packed {
    logic updated;
    logic store;
  } upd_flags_t;

  function automatic logic [1:0] drive_code(entry_t e);
    logic [1:0] c;
    case (e.mode)
      MODE_1:         c = CODE_MODE1;
      MODE_2:         c = CODE_MODE2;
      MODE_3:         c = CODE_FORCED;
      MODE_4, MODE_5: c = e.comfort ? CODE_COMFORT : CODE_FORCED;
      default:        c = CODE_COMFORT;
    endcase
    return c;
  endfunction

  function automatic logic [CNT_W-1:0] phase_len(logic [MODE_W-1:0] mode, logic comfort,
                                                 phase_cfg_t cfg);
    logic [CNT_W-1:0] len;
    if (mode == MODE_4) begin
      len = comfort ? cfg.m4_comfort : cfg.m4_eco;
    end else begin
      len = comfort ? cfg.m5_comfort : cfg.m5_eco;
    end
    return len;
  endfunction

endpackage

[src/pwhc_in_if.sv]
interface pwhc_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      action;
  logic [pwhc_pkg::CH_W-1:0]       channel;
  logic signed [pwhc_pkg::VALUE_W-1:0] value;

  modport source (output valid, action, channel, value, input ready);
  modport sink   (input valid, action, channel, value, output ready);
endinterface

[src/pwhc_out_if.sv]
interface pwhc_out_if;
  logic                        valid;
  logic                        ready;
  logic [pwhc_pkg::WORD_W-1:0] drive_word;
  logic                        updated;
  logic                        store_request;

  modport source (output valid, drive_word, updated, store_request, input ready);
  modport sink   (input valid, drive_word, updated, store_request, output ready);
endinterface

[src/pilot_wire_heater_controller.sv]
// A set word is written back in S_SET, then its result is loaded from S_DONE into the
// output register. A tick word sweeps all channels through the state memory, one per
// cycle, then moves to S_DONE; an unused code goes to S_DONE directly.
// Throughput: one word at a time; S_DONE holds until the output register is free, and
// the next word is accepted in the cycle after the result is loaded.
// Reset (rst_ni low, async): registers at default phase lengths, all channel entries read
// as zero through per-entry valid bits, drive word zero, no result pending.
module pilot_wire_heater_controller (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  pwhc_in_if.sink                           in_i,
  pwhc_out_if.source                        out_o,
  input  logic                              cfg_we_i,
  input  logic [pwhc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pwhc_pkg::CNT_W-1:0]        cfg_data_i
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SET  = 2'd1;
  localparam logic [1:0] S_TICK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  localparam logic [pwhc_pkg::CH_W-1:0] LAST_CH = pwhc_pkg::CH_W'(pwhc_pkg::CHANNELS - 1);

  logic [1:0] state_q, state_d;

  // config registers
  pwhc_pkg::phase_cfg_t cfg_q;

  // channel state memory: one entry per channel, registered read
  pwhc_pkg::entry_t mem [pwhc_pkg::CHANNELS];
  pwhc_pkg::entry_t rd_data_q;
  logic             rd_vld_q;
  logic [pwhc_pkg::CHANNELS-1:0] vld_q;
  logic [pwhc_pkg::CH_W-1:0]     rd_addr;

  // current channel (sweep counter during a tick)
  logic [pwhc_pkg::CH_W-1:0]  ch_q;
  logic [pwhc_pkg::LVL_W-1:0] level_q;
  logic                       upd_q;
  logic                       store_q;

  // cached drive codes, kept in sync with memory writes
  logic [1:0] code_q [pwhc_pkg::CHANNELS];
  logic [pwhc_pkg::WORD_W-1:0] word;

  // output register
  logic                        out_valid_q;
  logic [pwhc_pkg::WORD_W-1:0] out_word_q;
  logic                        out_upd_q;
  logic                        out_store_q;

  logic acc;
  logic busy;
  logic out_free;

  pwhc_pkg::entry_t     cur;
  pwhc_pkg::entry_t     nxt;
  pwhc_pkg::upd_flags_t flags;
  logic [1:0]           nxt_code;

  logic signed [pwhc_pkg::PROD_W-1:0] prod;
  logic [pwhc_pkg::LVL_W-1:0]         lvl_clamp;

  assign in_i.ready = (state_q == S_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign busy       = (state_q == S_SET) || (state_q == S_TICK);
  assign out_free   = !out_valid_q || out_o.ready;

  // config write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.m4_comfort <= pwhc_pkg::RST_M4_COMFORT;
      cfg_q.m4_eco     <= pwhc_pkg::RST_M4_ECO;
      cfg_q.m5_comfort <= pwhc_pkg::RST_M5_COMFORT;
      cfg_q.m5_eco     <= pwhc_pkg::RST_M5_ECO;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pwhc_pkg::CFG_M4_COMFORT: cfg_q.m4_comfort <= cfg_data_i;
        pwhc_pkg::CFG_M4_ECO:     cfg_q.m4_eco     <= cfg_data_i;
        pwhc_pkg::CFG_M5_COMFORT: cfg_q.m5_comfort <= cfg_data_i;
        pwhc_pkg::CFG_M5_ECO:     cfg_q.m5_eco     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // level request: a light value is scaled by 100, a dim value is used as is; both are clamped to 0..100
  always_comb begin
    if (in_i.action == pwhc_pkg::ACT_LIGHT) begin
      prod = pwhc_pkg::PROD_W'($signed(in_i.value) * $signed(pwhc_pkg::PROD_W'(100)));
    end else begin
      prod = pwhc_pkg::PROD_W'($signed(in_i.value));
    end
    if (prod > $signed(pwhc_pkg::PROD_W'(pwhc_pkg::LVL_MAX))) begin
      lvl_clamp = pwhc_pkg::LVL_MAX;
    end else if (prod < 0) begin
      lvl_clamp = '0;
    end else begin
      lvl_clamp = prod[pwhc_pkg::LVL_W-1:0];
    end
  end

  // Read address: on acceptance fetch the addressed channel (or channel 0 for a tick);
  // during a sweep fetch one ahead of the entry being written. Read and write never
  // hit the same entry in one cycle, so no forwarding is needed.
  always_comb begin
    if (state_q == S_IDLE) begin
      rd_addr = (in_i.action == pwhc_pkg::ACT_TICK) ? '0 : in_i.channel;
    end else begin
      rd_addr = ch_q + pwhc_pkg::CH_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr];
    if (busy) begin
      mem[ch_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= vld_q[rd_addr];
      if (busy) begin
        vld_q[ch_q] <= 1'b1;
      end
    end
  end

  // never-written entries read as the all-zero reset state
  assign cur = rd_vld_q ? rd_data_q : '0;

  pwhc_chan_upd u_upd (
    .is_tick_i (state_q == S_TICK),
    .level_i   (level_q),
    .cur_i     (cur),
    .cfg_i     (cfg_q),
    .nxt_o     (nxt),
    .flags_o   (flags),
    .code_o    (nxt_code)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_i.action == pwhc_pkg::ACT_TICK) begin
            state_d = S_TICK;
          end else if (((in_i.action == pwhc_pkg::ACT_DIM) ||
                        (in_i.action == pwhc_pkg::ACT_LIGHT)) &&
                       (32'(in_i.channel) < pwhc_pkg::CHANNELS)) begin
            state_d = S_SET;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SET:  state_d = S_DONE;
      S_TICK: begin
        if (ch_q == LAST_CH) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ch_q    <= '0;
      upd_q   <= 1'b0;
      store_q <= 1'b0;
      for (int i = 0; i < pwhc_pkg::CHANNELS; i++) begin
        code_q[i] <= pwhc_pkg::CODE_COMFORT;
      end
    end else begin
      state_q <= state_d;
      if (acc) begin
        ch_q    <= (in_i.action == pwhc_pkg::ACT_TICK) ? '0 : in_i.channel;
        upd_q   <= 1'b0;
        store_q <= 1'b0;
      end
      if (busy) begin
        code_q[ch_q] <= nxt_code;
        upd_q        <= upd_q | flags.updated;
        store_q      <= store_q | flags.store;
        if (state_q == S_TICK) begin
          ch_q <= ch_q + pwhc_pkg::CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      level_q <= lvl_clamp;
    end
  end

  // pack codes: channel 0 in the top two bits
  always_comb begin
    word = '0;
    for (int i = 0; i < pwhc_pkg::CHANNELS; i++) begin
      word[(pwhc_pkg::WORD_W - 2 - 2 * i) +: 2] = code_q[i];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_word_q  <= word;
      out_upd_q   <= upd_q;
      out_store_q <= store_q;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drive_word    = out_word_q;
  assign out_o.updated       = out_upd_q;
  assign out_o.store_request = out_store_q;

endmodule

[src/pwhc_chan_upd.sv]
// Per-channel read-modify-write datapath: tick timing or level set.
module pwhc_chan_upd (
  input  logic                         is_tick_i,
  input  logic [pwhc_pkg::LVL_W-1:0]   level_i,
  input  pwhc_pkg::entry_t             cur_i,
  input  pwhc_pkg::phase_cfg_t         cfg_i,
  output pwhc_pkg::entry_t             nxt_o,
  output pwhc_pkg::upd_flags_t         flags_o,
  output logic [1:0]                   code_o
);

  logic              timed;
  logic [pwhc_pkg::MODE_W-1:0] band;

  assign timed = (cur_i.mode == pwhc_pkg::MODE_4) || (cur_i.mode == pwhc_pkg::MODE_5);

  always_comb begin
    if (level_i <= pwhc_pkg::LVL_BAND_1) begin
      band = pwhc_pkg::MODE_1;
    end else if (level_i <= pwhc_pkg::LVL_BAND_2) begin
      band = pwhc_pkg::MODE_2;
    end else if (level_i <= pwhc_pkg::LVL_BAND_3) begin
      band = pwhc_pkg::MODE_3;
    end else if (level_i <= pwhc_pkg::LVL_BAND_4) begin
      band = pwhc_pkg::MODE_4;
    end else if (level_i <= pwhc_pkg::LVL_BAND_5) begin
      band = pwhc_pkg::MODE_5;
    end else begin
      band = pwhc_pkg::MODE_6;
    end
  end

  always_comb begin
    nxt_o   = cur_i;
    flags_o = '0;
    if (is_tick_i) begin
      if (timed) begin
        if (cur_i.countdown <= pwhc_pkg::CNT_W'(1)) begin
          nxt_o.comfort   = ~cur_i.comfort;
          nxt_o.countdown = pwhc_pkg::phase_len(cur_i.mode, ~cur_i.comfort, cfg_i);
          flags_o.updated = 1'b1;
        end else begin
          nxt_o.countdown = cur_i.countdown - pwhc_pkg::CNT_W'(1);
        end
      end
    end else if (level_i != cur_i.level) begin
      nxt_o.level     = level_i;
      nxt_o.mode      = band;
      flags_o.updated = 1'b1;
      flags_o.store   = 1'b1;
      if ((band == pwhc_pkg::MODE_4) || (band == pwhc_pkg::MODE_5)) begin
        nxt_o.comfort   = 1'b1;
        nxt_o.countdown = pwhc_pkg::phase_len(band, 1'b1, cfg_i);
      end
    end
  end

  assign code_o = pwhc_pkg::drive_code(nxt_o);

endmodule
